### rtl/rgb_to_hsv_converter_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the RGB to HSV converter
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_TOP_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define R2H_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define R2H_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/r2h_pkg.sv
// ----------------------------------------------------------------------------
// r2h_pkg
// Shared types, constants and the divider step for the RGB to HSV converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package r2h_pkg;

   localparam int CHAN_W    = 8;
   localparam int HUE_W     = 15;
   localparam int HUE_STEPS = 12;  // hue quotient bits, max 3840
   localparam int SAT_STEPS = 8;   // saturation quotient bits, max 255

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [HUE_W-1:0] HUE_FULL_TURN    = 15'd23040;
   localparam logic [HUE_W-1:0] HUE_OFFSET_GREEN = 15'd7680;
   localparam logic [HUE_W-1:0] HUE_OFFSET_BLUE  = 15'd15360;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   // classified pixel handed from the front to the back
   typedef struct packed {
      logic [CHAN_W-1:0] value;
      logic [CHAN_W-1:0] delta;
      logic [CHAN_W-1:0] diff_mag;
      logic              diff_neg;
      sector_type        sector;
      logic              undefined;
   } item_type;

   // One restoring division step. Returns {quotient bit, new remainder}.
   // Remainder stays below the divisor, so eight bits hold it.
   function automatic logic [CHAN_W:0] div_step(input logic [CHAN_W-1:0] rem,
                                                input logic nbit,
                                                input logic [CHAN_W-1:0] den);
      logic [CHAN_W:0] trial;
      logic [CHAN_W:0] diff;
      trial = {rem, nbit};
      diff  = trial - {1'b0, den};
      if (trial >= {1'b0, den}) begin
         return {1'b1, diff[CHAN_W-1:0]};
      end else begin
         return {1'b0, trial[CHAN_W-1:0]};
      end
   endfunction

endpackage

`default_nettype wire

### rtl/r2h_pixel_if.sv
// ----------------------------------------------------------------------------
// r2h_pixel_if
// Pixel channel: valid/ready plus 8-bit red, green and blue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface r2h_pixel_if import r2h_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

### rtl/r2h_hsv_if.sv
// ----------------------------------------------------------------------------
// r2h_hsv_if
// Result channel: valid/ready plus hue, saturation, value and hue_undefined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface r2h_hsv_if import r2h_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [HUE_W-1:0]  hue;
   logic [CHAN_W-1:0] saturation;
   logic [CHAN_W-1:0] value;
   logic              hue_undefined;

   modport source (output valid, output hue, output saturation, output value,
                   output hue_undefined, input ready);
   modport sink   (input valid, input hue, input saturation, input value,
                   input hue_undefined, output ready);
endinterface

`default_nettype wire

### rtl/r2h_front.sv
// ----------------------------------------------------------------------------
// r2h_front
// Accepts pixels, finds max/min/delta, picks the hue sector and the signed
// channel difference, and registers the classified item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module r2h_front import r2h_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   r2h_pixel_if.sink  req_bus,
   output logic       out_valid,
   input  logic       out_ready,
   output item_type   out_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;

   logic [CHAN_W-1:0] mx, mn, rg_max, rg_min;
   logic [CHAN_W:0]   diff;

   assign req_bus.ready = !valid_ff || out_ready;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      rg_max = (req_bus.red > req_bus.green) ? req_bus.red : req_bus.green;
      rg_min = (req_bus.red < req_bus.green) ? req_bus.red : req_bus.green;
      mx     = (req_bus.blue > rg_max) ? req_bus.blue : rg_max;
      mn     = (req_bus.blue < rg_min) ? req_bus.blue : rg_min;

      item_in.value     = mx;
      item_in.delta     = mx - mn;
      item_in.undefined = (mx == mn);

      // ties: red wins over green, green over blue
      if (req_bus.red >= mx) begin
         item_in.sector = SECTOR_RED;
         diff = {1'b0, req_bus.green} - {1'b0, req_bus.blue};
      end else if (req_bus.green >= mx) begin
         item_in.sector = SECTOR_GREEN;
         diff = {1'b0, req_bus.blue} - {1'b0, req_bus.red};
      end else begin
         item_in.sector = SECTOR_BLUE;
         diff = {1'b0, req_bus.red} - {1'b0, req_bus.green};
      end

      item_in.diff_neg = diff[CHAN_W];
      item_in.diff_mag = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

### rtl/r2h_queue.sv
// ----------------------------------------------------------------------------
// r2h_queue
// Short FIFO of classified items between the front and the divider pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module r2h_queue import r2h_pkg::*; #(
   parameter int Depth = QUEUE_DEPTH_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CNT_W = $clog2(Depth + 1);

   item_type           entry_ff [Depth];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign in_ready  = (count_ff != CNT_W'(Depth));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

`default_nettype wire

### rtl/r2h_back.sv
// ----------------------------------------------------------------------------
// r2h_back
// Pipelined restoring dividers, one quotient bit per stage: hue fraction
// 3840*|diff|/delta over twelve stages, saturation 255*delta/max over the
// first eight. A final stage applies the sector offset and wrap and holds
// the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module r2h_back import r2h_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  item_type   in_item,
   r2h_hsv_if.source  rsp_bus
);

   localparam int HUE_NUM_W = CHAN_W + HUE_STEPS;
   localparam int SAT_NUM_W = CHAN_W + SAT_STEPS;

   typedef struct packed {
      item_type                item;
      logic [CHAN_W-1:0]       hue_rem;
      logic [HUE_STEPS-1:0]    hue_bits;  // numerator bits out the top, quotient in
      logic [CHAN_W-1:0]       sat_rem;
      logic [SAT_STEPS-1:0]    sat_bits;
   } stage_type;

   stage_type              stage_ff [HUE_STEPS];
   stage_type              init_stage;
   logic [HUE_STEPS-1:0]   valid_ff;
   logic                   advance;

   logic [HUE_NUM_W-1:0]   hue_num;
   logic [SAT_NUM_W-1:0]   sat_num;

   logic                   rsp_valid_ff;
   logic [HUE_W-1:0]       hue_ff, hue_in;
   logic [CHAN_W-1:0]      sat_ff, sat_in;
   logic [CHAN_W-1:0]      value_ff;
   logic                   undef_ff;
   logic [HUE_W-1:0]       quot;
   stage_type              last;

   // the whole pipe moves when the output beat is free or being taken
   assign advance  = !rsp_valid_ff || rsp_bus.ready;
   assign in_ready = advance;

   // constant multiplies as shift and subtract
   always_comb begin
      hue_num = (HUE_NUM_W'(in_item.diff_mag) << HUE_STEPS)
              - (HUE_NUM_W'(in_item.diff_mag) << CHAN_W);
      sat_num = (SAT_NUM_W'(in_item.delta) << SAT_STEPS) - SAT_NUM_W'(in_item.delta);
      init_stage.item     = in_item;
      init_stage.hue_rem  = hue_num[HUE_NUM_W-1:HUE_STEPS];
      init_stage.hue_bits = hue_num[HUE_STEPS-1:0];
      init_stage.sat_rem  = sat_num[SAT_NUM_W-1:SAT_STEPS];
      init_stage.sat_bits = sat_num[SAT_STEPS-1:0];
   end

   for (genvar k = 0; k < HUE_STEPS; k++) begin : g_step
      stage_type       src;
      stage_type       stage_in;
      logic [CHAN_W:0] hue_res;
      logic [CHAN_W:0] sat_res;

      if (k == 0) begin : g_first
         assign src = init_stage;
      end else begin : g_rest
         assign src = stage_ff[k-1];
      end

      always_comb begin
         stage_in = src;
         hue_res  = div_step(src.hue_rem, src.hue_bits[HUE_STEPS-1], src.item.delta);
         stage_in.hue_rem  = hue_res[CHAN_W-1:0];
         stage_in.hue_bits = {src.hue_bits[HUE_STEPS-2:0], hue_res[CHAN_W]};
         sat_res  = div_step(src.sat_rem, src.sat_bits[SAT_STEPS-1], src.item.value);
         if (k < SAT_STEPS) begin
            stage_in.sat_rem  = sat_res[CHAN_W-1:0];
            stage_in.sat_bits = {src.sat_bits[SAT_STEPS-2:0], sat_res[CHAN_W]};
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            stage_ff[k] <= stage_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[HUE_STEPS-2:0], in_valid};
      end
   end

   // sector offset, signed fraction, wrap of negative red hues
   assign last = stage_ff[HUE_STEPS-1];
   assign quot = HUE_W'(last.hue_bits);

   always_comb begin
      case (last.item.sector)
         SECTOR_GREEN: hue_in = last.item.diff_neg ? HUE_OFFSET_GREEN - quot
                                                   : HUE_OFFSET_GREEN + quot;
         SECTOR_BLUE:  hue_in = last.item.diff_neg ? HUE_OFFSET_BLUE - quot
                                                   : HUE_OFFSET_BLUE + quot;
         default: begin
            // truncation to zero leaves no wrap
            if (last.item.diff_neg && (quot != '0)) begin
               hue_in = HUE_FULL_TURN - quot;
            end else begin
               hue_in = quot;
            end
         end
      endcase
      sat_in = last.sat_bits;
      if (last.item.undefined) begin
         hue_in = '0;
         sat_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid_ff[HUE_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hue_ff   <= hue_in;
         sat_ff   <= sat_in;
         value_ff <= last.item.value;
         undef_ff <= last.item.undefined;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.hue           = hue_ff;
   assign rsp_bus.saturation    = sat_ff;
   assign rsp_bus.value         = value_ff;
   assign rsp_bus.hue_undefined = undef_ff;

endmodule

`default_nettype wire

### rtl/rgb_to_hsv_converter_top.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_top
// RGB to HSV conversion: front classifier, item queue, divider pipeline.
// ----------------------------------------------------------------------------
//   channel   dir  handshake     payload
//   req_bus   in   valid/ready   red[7:0] green[7:0] blue[7:0]
//   rsp_bus   out  valid/ready   hue[14:0] saturation[7:0] value[7:0] hue_undefined
//
// One pixel per cycle sustained while rsp_bus.ready holds. A pixel passes the front
// register, the queue, the twelve-stage hue divider and the output register.
// Reset is synchronous and clears only the valid and queue control state.
// A stall on rsp_bus freezes the divider pipe; the queue keeps taking beats
// from the front until it fills, then req_bus.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_to_hsv_converter_top_macros.svh"

module rgb_to_hsv_converter_top import r2h_pkg::*; #(
   parameter int QueueDepth = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   r2h_pixel_if.sink  req_bus,
   r2h_hsv_if.source  rsp_bus
);

   logic     front_valid, front_ready;
   item_type front_item;
   logic     queue_valid, queue_ready;
   item_type queue_item;

   r2h_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_item  (front_item)
   );

   r2h_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_item  (queue_item)
   );

   r2h_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (queue_valid),
      .in_ready (queue_ready),
      .in_item  (queue_item),
      .rsp_bus  (rsp_bus)
   );

   `R2H_ASSERT_IMPLY(a_grey_zero, clock, reset,
      rsp_bus.valid && rsp_bus.hue_undefined,
      (rsp_bus.hue == '0) && (rsp_bus.saturation == '0), "grey pixel with nonzero hue/sat")

   `R2H_ASSERT_IMPLY(a_hue_range, clock, reset,
      rsp_bus.valid, rsp_bus.hue < HUE_FULL_TURN, "hue beyond full turn")

   `R2H_ASSERT_IMPLY(a_color_nonzero, clock, reset,
      rsp_bus.valid && !rsp_bus.hue_undefined,
      (rsp_bus.value != '0) && (rsp_bus.saturation != '0), "colored pixel with zero sat")

   `R2H_ASSERT_NEXT(a_front_hold, clock, reset,
      front_valid && !front_ready, front_valid && $stable(front_item),
      "front item lost while queue full")

endmodule

`default_nettype wire

### verif/rgb_to_hsv_converter_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_top_test
// Drives pixels into the converter with random gaps and output stalls,
// predicts each HSV result, and compares every returned beat field by field.
// ----------------------------------------------------------------------------

module rgb_to_hsv_converter_top_test;
   import r2h_pkg::*;

   localparam int HueSixth      = 3840;  // 60 degrees in 1/64 degree
   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles   = 20;
   localparam int MaxReports    = 60;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [CHAN_W-1:0] saturation;
      logic [CHAN_W-1:0] value;
      logic              hue_undefined;
   } hsv_result_type;

   logic clock = 1'b0;
   logic reset;

   r2h_pixel_if pix_bus ();
   r2h_hsv_if   hsv_bus ();

   rgb_to_hsv_converter_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (pix_bus),
      .rsp_bus (hsv_bus)
   );

   hsv_result_type hsv_pending_q[$];
   int             mismatch_count = 0;
   int             idle_cycles    = 0;
   int             sink_hold      = 0;
   bit             sender_gaps_on = 1'b0;
   bit             sink_stalls_on = 1'b0;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic hsv_result_type convert_pixel(input logic [CHAN_W-1:0] red,
                                                    input logic [CHAN_W-1:0] green,
                                                    input logic [CHAN_W-1:0] blue);
      int             r, g, b, mx, mn, delta, diff, offset, hue;
      sector_type     sector;
      hsv_result_type res;
      r  = red;
      g  = green;
      b  = blue;
      mx = (r > g) ? r : g;
      mx = (b > mx) ? b : mx;
      mn = (r < g) ? r : g;
      mn = (b < mn) ? b : mn;
      delta = mx - mn;
      res.value = mx[CHAN_W-1:0];
      if (delta == 0) begin
         res.hue           = '0;
         res.saturation    = '0;
         res.hue_undefined = 1'b1;
         return res;
      end
      // ties: red beats green, green beats blue
      if (r >= mx) begin
         sector = SECTOR_RED;
         diff   = g - b;
      end else if (g >= mx) begin
         sector = SECTOR_GREEN;
         diff   = b - r;
      end else begin
         sector = SECTOR_BLUE;
         diff   = r - g;
      end
      case (sector)
         SECTOR_GREEN: offset = int'(HUE_OFFSET_GREEN);
         SECTOR_BLUE:  offset = int'(HUE_OFFSET_BLUE);
         default:      offset = 0;
      endcase
      // signed int division truncates toward zero
      hue = offset + (HueSixth * diff) / delta;
      if (hue < 0) hue += int'(HUE_FULL_TURN);
      res.hue           = hue[HUE_W-1:0];
      res.saturation    = 8'((255 * delta) / mx);
      res.hue_undefined = 1'b0;
      return res;
   endfunction

   // caller sits on a rising edge; valid stays high on return
   task automatic send_pixel(input logic [CHAN_W-1:0] red,
                             input logic [CHAN_W-1:0] green,
                             input logic [CHAN_W-1:0] blue);
      int gap;
      gap = sender_gaps_on ? gap_length() : 0;
      if (gap > 0) begin
         pix_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pix_bus.valid <= 1'b1;
      pix_bus.red   <= red;
      pix_bus.green <= green;
      pix_bus.blue  <= blue;
      do @(posedge clock); while (!pix_bus.ready);
      hsv_pending_q.push_back(convert_pixel(red, green, blue));
   endtask

   task automatic wait_drain();
      pix_bus.valid <= 1'b0;
      while (hsv_pending_q.size() != 0) @(posedge clock);
   endtask

   task automatic report_field(input string name, input int exp_val, input int act_val);
      mismatch_count++;
      if (mismatch_count <= MaxReports)
         $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                  $time, name, exp_val, act_val);
   endtask

   // ---- result checker ----
   always @(posedge clock) begin
      hsv_result_type want;
      if (!reset && hsv_bus.valid && hsv_bus.ready) begin
         if (hsv_pending_q.size() == 0) begin
            report_field("unexpected beat, hue", -1, hsv_bus.hue);
         end else begin
            want = hsv_pending_q.pop_front();
            if (hsv_bus.hue !== want.hue)
               report_field("hue", want.hue, hsv_bus.hue);
            if (hsv_bus.saturation !== want.saturation)
               report_field("saturation", want.saturation, hsv_bus.saturation);
            if (hsv_bus.value !== want.value)
               report_field("value", want.value, hsv_bus.value);
            if (hsv_bus.hue_undefined !== want.hue_undefined)
               report_field("hue_undefined", want.hue_undefined, hsv_bus.hue_undefined);
         end
      end
   end

   // ---- output stall generator ----
   always @(posedge clock) begin
      if (sink_hold > 0) begin
         sink_hold <= sink_hold - 1;
      end else if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
         hsv_bus.ready <= 1'b0;
         sink_hold     <= gap_length();
      end else begin
         hsv_bus.ready <= 1'b1;
         sink_hold     <= sink_stalls_on ? $urandom_range(0, 4) : 0;
      end
   end

   // ---- watchdog: cycles without any beat on either side ----
   always @(posedge clock) begin
      if ((pix_bus.valid && pix_bus.ready) || (hsv_bus.valid && hsv_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("%0t ns: watchdog expired", $time);
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---- tests ----
   task automatic test_directed_corners();
      sender_gaps_on = 1'b1;
      sink_stalls_on = 1'b1;
      send_pixel(8'd0,   8'd0,   8'd0);    // black, grey with zero max
      send_pixel(8'd255, 8'd255, 8'd255);  // white
      send_pixel(8'd128, 8'd128, 8'd128);  // mid grey
      send_pixel(8'd255, 8'd0,   8'd0);    // pure red
      send_pixel(8'd0,   8'd255, 8'd0);    // pure green
      send_pixel(8'd0,   8'd0,   8'd255);  // pure blue
      send_pixel(8'd255, 8'd255, 8'd0);    // red/green tie, red wins
      send_pixel(8'd0,   8'd255, 8'd255);  // green/blue tie, green wins
      send_pixel(8'd255, 8'd0,   8'd255);  // red/blue tie, red wins, wraps
      send_pixel(8'd255, 8'd0,   8'd1);    // red sector, small negative
      send_pixel(8'd255, 8'd0,   8'd254);  // red sector, large negative
      send_pixel(8'd200, 8'd50,  8'd50);   // zero fraction, no wrap
      send_pixel(8'd1,   8'd0,   8'd0);
      send_pixel(8'd0,   8'd1,   8'd0);
      send_pixel(8'd0,   8'd0,   8'd1);
      send_pixel(8'd255, 8'd254, 8'd254);
      send_pixel(8'd254, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd127, 8'd129);
      send_pixel(8'd85,  8'd170, 8'd255);
      send_pixel(8'd255, 8'd1,   8'd0);
      send_pixel(8'd2,   8'd1,   8'd0);
      send_pixel(8'd0,   8'd2,   8'd1);
      wait_drain();
   endtask

   task automatic test_random_pixels(input int count);
      sender_gaps_on = 1'b1;
      sink_stalls_on = 1'b1;
      repeat (count)
         send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
      wait_drain();
   endtask

   // small deltas and forced ties
   task automatic test_near_grey(input int count);
      int base, chan[3], k;
      sender_gaps_on = 1'b1;
      sink_stalls_on = 1'b1;
      repeat (count) begin
         base = $urandom_range(0, 255);
         for (k = 0; k < 3; k++) begin
            chan[k] = base + $urandom_range(0, 6) - 3;
            if (chan[k] < 0)   chan[k] = 0;
            if (chan[k] > 255) chan[k] = 255;
         end
         if ($urandom_range(0, 2) == 0) chan[$urandom_range(0, 2)] = chan[$urandom_range(0, 2)];
         send_pixel(8'(chan[0]), 8'(chan[1]), 8'(chan[2]));
      end
      wait_drain();
   endtask

   task automatic test_full_rate(input int count);
      sender_gaps_on = 1'b0;
      sink_stalls_on = 1'b0;
      repeat (count)
         send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
      wait_drain();
   endtask

   task automatic test_backpressure(input int count);
      sender_gaps_on = 1'b0;
      sink_stalls_on = 1'b1;
      repeat (count)
         send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
      wait_drain();
   endtask

   initial begin
      reset         = 1'b1;
      pix_bus.valid = 1'b0;
      pix_bus.red   = '0;
      pix_bus.green = '0;
      pix_bus.blue  = '0;
      hsv_bus.ready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_corners();
      test_random_pixels(700);
      test_near_grey(450);
      test_full_rate(350);
      test_backpressure(330);

      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
